>>> rtl/idr_pkg.sv
// ---------------------------------------------------------------------------
// idr_pkg
// shared types, widths and constants of the imu dead-reckoning integrator
// ---------------------------------------------------------------------------
`default_nettype none

package idr_pkg;

  localparam int TIME_W    = 63;
  localparam int ACCEL_W   = 32;
  localparam int QUAT_W    = 32;
  localparam int RATE_W    = 32;
  localparam int OUT_W     = 48;
  localparam int GRAV_W    = 31;
  localparam int CAP_W     = 30;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 31;

  // defaults for the top level parameters
  localparam int ACCEL_FRAC_BITS_DEF = 16;
  localparam int ACCUM_WIDTH_DEF     = 48;

  // internal widths
  localparam int ACC_W  = 36;  // gravity-compensated acceleration
  localparam int MUL_BW = 33;  // multiplier b operand, one bit per cycle
  localparam int QP_W   = 34;  // quaternion product after the q30 shift
  localparam int DT_W   = 32;  // step in seconds, q0.32

  localparam logic [CAP_W-1:0] CAP_RESET  = 30'd200000000;
  localparam logic [31:0]      RECIP_LOW  = 32'd1266874890;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REMOVAL_ON = 2'd0,
    REG_BY_ORIENT  = 2'd1,
    REG_GRAVITY    = 2'd2,
    REG_STEP_CAP   = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_START,
    ST_WAIT,
    ST_TERMS,
    ST_ZSUB,
    ST_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_DT, OP_XZ, OP_WY, OP_YZ, OP_WX, OP_XX, OP_YY,
    OP_GX, OP_GY, OP_GZ,
    OP_VX, OP_PX, OP_VY, OP_PY, OP_VZ, OP_PZ
  } op_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

  // clamp a quaternion term to the signed 32-bit range
  function automatic logic signed [31:0] clamp_term(input logic signed [36:0] v);
    logic signed [31:0] r;
    if (v > 37'sh007FFFFFFF) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -37'sh0080000000) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/idr_in_if.sv
// ---------------------------------------------------------------------------
// idr_in_if
// input sample channel: valid, ready and one imu sample
// ---------------------------------------------------------------------------
`default_nettype none

interface idr_in_if;
  import idr_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [TIME_W-1:0]         sample_time_ns;
  logic signed [ACCEL_W-1:0] accel_x;
  logic signed [ACCEL_W-1:0] accel_y;
  logic signed [ACCEL_W-1:0] accel_z;
  logic signed [QUAT_W-1:0]  quat_w;
  logic signed [QUAT_W-1:0]  quat_x;
  logic signed [QUAT_W-1:0]  quat_y;
  logic signed [QUAT_W-1:0]  quat_z;
  logic signed [RATE_W-1:0]  rate_x;
  logic signed [RATE_W-1:0]  rate_y;
  logic signed [RATE_W-1:0]  rate_z;

  modport source (
    output valid, sample_time_ns, accel_x, accel_y, accel_z,
           quat_w, quat_x, quat_y, quat_z, rate_x, rate_y, rate_z,
    input  ready
  );

  modport sink (
    input  valid, sample_time_ns, accel_x, accel_y, accel_z,
           quat_w, quat_x, quat_y, quat_z, rate_x, rate_y, rate_z,
    output ready
  );

endinterface

`default_nettype wire

>>> rtl/idr_out_if.sv
// ---------------------------------------------------------------------------
// idr_out_if
// result channel: valid, ready and one position/velocity result
// ---------------------------------------------------------------------------
`default_nettype none

interface idr_out_if;
  import idr_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [TIME_W-1:0]        out_time_ns;
  logic signed [OUT_W-1:0]  pos_x;
  logic signed [OUT_W-1:0]  pos_y;
  logic signed [OUT_W-1:0]  pos_z;
  logic signed [OUT_W-1:0]  vel_x;
  logic signed [OUT_W-1:0]  vel_y;
  logic signed [OUT_W-1:0]  vel_z;
  logic signed [RATE_W-1:0] out_rate_x;
  logic signed [RATE_W-1:0] out_rate_y;
  logic signed [RATE_W-1:0] out_rate_z;

  modport source (
    output valid, out_time_ns, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
           out_rate_x, out_rate_y, out_rate_z,
    input  ready
  );

  modport sink (
    input  valid, out_time_ns, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
           out_rate_x, out_rate_y, out_rate_z,
    output ready
  );

endinterface

`default_nettype wire

>>> rtl/idr_sermul.sv
// ---------------------------------------------------------------------------
// idr_sermul
// bit-serial signed multiplier, one bit of b per cycle, shift-right product
// ---------------------------------------------------------------------------
`default_nettype none

module idr_sermul #(
  parameter int AW = 40,
  parameter int BW = 33
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic signed [AW-1:0]     a,
  input  wire logic signed [BW-1:0]     b,
  output idr_pkg::mul_stat_t            stat,
  output logic signed [AW+BW:0]         prod
);
  import idr_pkg::*;

  localparam int CW = (BW > 1) ? $clog2(BW) : 1;

  logic signed [AW-1:0] a_r;
  logic signed [AW:0]   hi_r, hi_nxt;
  logic [BW-1:0]        lo_r, lo_nxt;
  logic [CW-1:0]        cnt_r;
  logic                 busy_r, done_r;
  logic                 last;
  logic signed [AW+1:0] addend, sum;

  assign last = (cnt_r == CW'(BW - 1));

  always_comb begin
    addend = '0;
    if (lo_r[0]) begin
      // sign bit of b carries negative weight
      addend = last ? -(AW+2)'(a_r) : (AW+2)'(a_r);
    end
    sum    = (AW+2)'(hi_r) + addend;
    hi_nxt = sum[AW+1:1];
    lo_nxt = {sum[0], lo_r[BW-1:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      hi_r <= '0;
      lo_r <= b;
    end else if (busy_r) begin
      hi_r <= hi_nxt;
      lo_r <= lo_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign prod      = {hi_r, lo_r};

endmodule

`default_nettype wire

>>> rtl/imu_dead_reckoning_integrator.sv
// ---------------------------------------------------------------------------
// imu_dead_reckoning_integrator
// euler dead reckoning of imu samples with gravity compensation
// ---------------------------------------------------------------------------
// sequence: an accepted sample runs n multiplies before its result is valid:
//   16 with orientation-based gravity, 7 otherwise, plus a z subtraction
//   state with removal on but not by orientation; a skipped sample returns
//   from the check state to idle; one sample at a time, set by the shared
//   bit-serial multiplier (per product: load, 33 steps of one b bit each, done)
// reset: synchronous active low; registers at their reset values, no sample
//   seen, velocity and position zero
`default_nettype none

module imu_dead_reckoning_integrator #(
  parameter int ACCEL_FRAC_BITS = idr_pkg::ACCEL_FRAC_BITS_DEF,
  parameter int ACCUM_WIDTH     = idr_pkg::ACCUM_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  idr_in_if.sink                             in_ch,
  idr_out_if.source                          out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [idr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [idr_pkg::CFG_W-1:0]     cfg_data
);
  import idr_pkg::*;

  // multiplier a operand covers accumulators and compensated acceleration
  localparam int MUL_AW = (ACCUM_WIDTH > ACC_W + 4) ? ACCUM_WIDTH : ACC_W + 4;
  localparam int PW     = MUL_AW + MUL_BW + 1;
  localparam int SW     = MUL_AW + 1;
  localparam longint unsigned GRAV_RST =
    ((64'd981 << ACCEL_FRAC_BITS) + 64'd50) / 64'd100;

  localparam logic signed [ACCUM_WIDTH-1:0] ACC_MAX = {1'b0, {(ACCUM_WIDTH-1){1'b1}}};
  localparam logic signed [ACCUM_WIDTH-1:0] ACC_MIN = {1'b1, {(ACCUM_WIDTH-1){1'b0}}};

  // configuration registers
  logic              rem_on_r, by_orient_r;
  logic [GRAV_W-1:0] grav_r;
  logic [CAP_W-1:0]  cap_r;

  // sequencer
  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;

  // integrator state
  logic                          time_seen_r;
  logic [TIME_W-1:0]             prev_r;
  logic signed [ACCUM_WIDTH-1:0] vel_r [3];
  logic signed [ACCUM_WIDTH-1:0] pos_r [3];

  // latched sample
  logic [TIME_W-1:0]         t_r;
  logic signed [ACCEL_W-1:0] ax_r, ay_r, az_r;
  logic signed [QUAT_W-1:0]  qw_r, qx_r, qy_r, qz_r;
  logic signed [RATE_W-1:0]  rx_r, ry_r, rz_r;

  // working values
  logic [CAP_W-1:0]         dn_r;
  logic [DT_W-1:0]          dt_r;
  logic signed [QP_W-1:0]   qxz_r, qwy_r, qyz_r, qwx_r, qxx_r, qyy_r;
  logic signed [31:0]       tx_r, ty_r, tz_r;
  logic signed [ACC_W-1:0]  acc_r [3];

  // result register
  logic                     out_valid_r;
  logic [TIME_W-1:0]        o_time_r;
  logic signed [OUT_W-1:0]  o_pos_r [3];
  logic signed [OUT_W-1:0]  o_vel_r [3];
  logic signed [RATE_W-1:0] o_rx_r, o_ry_r, o_rz_r;

  // multiplier
  logic                     mul_start;
  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  mul_stat_t                mul_stat;
  logic signed [PW-1:0]     prod;

  idr_sermul #(
    .AW (MUL_AW),
    .BW (MUL_BW)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .stat  (mul_stat),
    .prod  (prod)
  );

  // step checks on the latched sample
  logic signed [63:0] diff;
  logic               skip;
  logic               over_cap;
  assign diff     = $signed({1'b0, t_r}) - $signed({1'b0, prev_r});
  assign skip     = !time_seen_r || diff[63] || (diff == 64'sd0);
  assign over_cap = (diff[63:CAP_W] != '0) || (diff[CAP_W-1:0] > cap_r);

  // step in seconds: dn * 4 + (dn * recip) / 2^32, saturated to 32 bits
  logic [DT_W:0] dts;
  assign dts = {1'b0, dn_r, 2'b00} + {1'b0, prod[63:32]};

  // axis of the integration ops
  logic [1:0] ax;
  logic       is_vel;
  always_comb begin
    ax     = 2'd0;
    is_vel = 1'b0;
    unique case (op_r)
      OP_VX: begin ax = 2'd0; is_vel = 1'b1; end
      OP_PX: begin ax = 2'd0; end
      OP_VY: begin ax = 2'd1; is_vel = 1'b1; end
      OP_PY: begin ax = 2'd1; end
      OP_VZ: begin ax = 2'd2; is_vel = 1'b1; end
      OP_PZ: begin ax = 2'd2; end
      default: begin ax = 2'd0; end
    endcase
  end

  // saturating accumulate of floor(value * dt / 2^32)
  logic signed [MUL_AW-1:0]      inc;
  logic signed [ACCUM_WIDTH-1:0] base;
  logic signed [SW-1:0]          sum;
  logic signed [ACCUM_WIDTH-1:0] sat;
  always_comb begin
    inc  = prod[MUL_AW+31:32];
    base = is_vel ? vel_r[ax] : pos_r[ax];
    sum  = SW'(base) + SW'(inc);
    if (sum > SW'(ACC_MAX)) begin
      sat = ACC_MAX;
    end else if (sum < SW'(ACC_MIN)) begin
      sat = ACC_MIN;
    end else begin
      sat = sum[ACCUM_WIDTH-1:0];
    end
  end

  // rotated gravity terms, each floored then clamped
  logic signed [36:0] tx_full, ty_full, tz_full;
  logic signed [36:0] sq_sum;
  always_comb begin
    tx_full = 37'(qxz_r) - 37'(qwy_r);
    ty_full = 37'(qyz_r) + 37'(qwx_r);
    sq_sum  = 37'(qxx_r) + 37'(qyy_r);
    tz_full = 37'sh0040000000 - (sq_sum <<< 1);
  end

  // operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (op_r)
      OP_DT: begin
        mul_a = MUL_AW'($signed({1'b0, dn_r}));
        mul_b = MUL_BW'($signed({1'b0, RECIP_LOW}));
      end
      OP_XZ: begin mul_a = MUL_AW'(qx_r); mul_b = MUL_BW'(qz_r); end
      OP_WY: begin mul_a = MUL_AW'(qw_r); mul_b = MUL_BW'(qy_r); end
      OP_YZ: begin mul_a = MUL_AW'(qy_r); mul_b = MUL_BW'(qz_r); end
      OP_WX: begin mul_a = MUL_AW'(qw_r); mul_b = MUL_BW'(qx_r); end
      OP_XX: begin mul_a = MUL_AW'(qx_r); mul_b = MUL_BW'(qx_r); end
      OP_YY: begin mul_a = MUL_AW'(qy_r); mul_b = MUL_BW'(qy_r); end
      OP_GX: begin mul_a = MUL_AW'(tx_r); mul_b = $signed({2'b00, grav_r}); end
      OP_GY: begin mul_a = MUL_AW'(ty_r); mul_b = $signed({2'b00, grav_r}); end
      OP_GZ: begin mul_a = MUL_AW'(tz_r); mul_b = $signed({2'b00, grav_r}); end
      OP_VX, OP_VY, OP_VZ: begin
        mul_a = MUL_AW'(acc_r[ax]);
        mul_b = $signed({1'b0, dt_r});
      end
      OP_PX, OP_PY, OP_PZ: begin
        mul_a = MUL_AW'(vel_r[ax]);
        mul_b = $signed({1'b0, dt_r});
      end
      default: begin mul_a = '0; end
    endcase
  end

  // next state
  logic slot_free;
  assign slot_free = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    mul_start = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (skip) begin
          state_nxt = ST_IDLE;
        end else begin
          op_nxt    = OP_DT;
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        mul_start = 1'b1;
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (mul_stat.done) begin
          state_nxt = ST_START;
          op_nxt    = op_t'(op_r + 4'd1);
          priority case (1'b1)
            op_r == OP_DT: begin
              if (rem_on_r && by_orient_r) begin
                op_nxt = OP_XZ;
              end else if (rem_on_r) begin
                state_nxt = ST_ZSUB;
              end else begin
                op_nxt = OP_VX;
              end
            end
            op_r == OP_YY: state_nxt = ST_TERMS;
            op_r == OP_PZ: state_nxt = ST_OUT;
            default: state_nxt = ST_START;
          endcase
        end
      end
      ST_TERMS: begin
        op_nxt    = OP_GX;
        state_nxt = ST_START;
      end
      ST_ZSUB: begin
        op_nxt    = OP_VX;
        state_nxt = ST_START;
      end
      ST_OUT: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_ch.ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r    <= OP_DT;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_on_r    <= 1'b1;
      by_orient_r <= 1'b0;
      grav_r      <= GRAV_W'(GRAV_RST);
      cap_r       <= CAP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_REMOVAL_ON: rem_on_r    <= cfg_data[0];
        REG_BY_ORIENT:  by_orient_r <= cfg_data[0];
        REG_GRAVITY:    grav_r      <= cfg_data[GRAV_W-1:0];
        REG_STEP_CAP:   cap_r       <= cfg_data[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  // integrator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_seen_r <= 1'b0;
      prev_r      <= '0;
      for (int i = 0; i < 3; i++) begin
        vel_r[i] <= '0;
        pos_r[i] <= '0;
      end
    end else begin
      if (state_r == ST_CHECK && skip) begin
        time_seen_r <= 1'b1;
        prev_r      <= t_r;
      end
      if (state_r == ST_OUT && slot_free) begin
        prev_r <= t_r;
      end
      if (state_r == ST_WAIT && mul_stat.done) begin
        unique case (op_r)
          OP_VX, OP_VY, OP_VZ: vel_r[ax] <= sat;
          OP_PX, OP_PY, OP_PZ: pos_r[ax] <= sat;
          default: ;
        endcase
      end
    end
  end

  // sample capture and working values
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      t_r  <= in_ch.sample_time_ns;
      ax_r <= in_ch.accel_x;
      ay_r <= in_ch.accel_y;
      az_r <= in_ch.accel_z;
      qw_r <= in_ch.quat_w;
      qx_r <= in_ch.quat_x;
      qy_r <= in_ch.quat_y;
      qz_r <= in_ch.quat_z;
      rx_r <= in_ch.rate_x;
      ry_r <= in_ch.rate_y;
      rz_r <= in_ch.rate_z;
    end
    if (state_r == ST_CHECK) begin
      dn_r     <= over_cap ? cap_r : diff[CAP_W-1:0];
      acc_r[0] <= ACC_W'(ax_r);
      acc_r[1] <= ACC_W'(ay_r);
      acc_r[2] <= ACC_W'(az_r);
    end
    if (state_r == ST_TERMS) begin
      tx_r <= clamp_term(tx_full);
      ty_r <= clamp_term(ty_full);
      tz_r <= clamp_term(tz_full);
    end
    if (state_r == ST_ZSUB) begin
      acc_r[2] <= acc_r[2] - ACC_W'($signed({1'b0, grav_r}));
    end
    if (state_r == ST_WAIT && mul_stat.done) begin
      unique case (op_r)
        OP_DT: dt_r  <= dts[DT_W] ? '1 : dts[DT_W-1:0];
        OP_XZ: qxz_r <= prod[63:30];
        OP_WY: qwy_r <= prod[63:30];
        OP_YZ: qyz_r <= prod[63:30];
        OP_WX: qwx_r <= prod[63:30];
        OP_XX: qxx_r <= prod[63:30];
        OP_YY: qyy_r <= prod[63:30];
        // x and y gravity terms are twice the q30 products
        OP_GX: acc_r[0] <= acc_r[0] - prod[64:29];
        OP_GY: acc_r[1] <= acc_r[1] - prod[64:29];
        OP_GZ: acc_r[2] <= acc_r[2] - prod[65:30];
        default: ;
      endcase
    end
  end

  // result register, refilled when empty or as the previous transfer completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_OUT && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.valid && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && slot_free) begin
      o_time_r <= t_r;
      for (int i = 0; i < 3; i++) begin
        o_pos_r[i] <= OUT_W'(pos_r[i]);
        o_vel_r[i] <= OUT_W'(vel_r[i]);
      end
      o_rx_r <= rx_r;
      o_ry_r <= ry_r;
      o_rz_r <= rz_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_time_ns = o_time_r;
  assign out_ch.pos_x       = o_pos_r[0];
  assign out_ch.pos_y       = o_pos_r[1];
  assign out_ch.pos_z       = o_pos_r[2];
  assign out_ch.vel_x       = o_vel_r[0];
  assign out_ch.vel_y       = o_vel_r[1];
  assign out_ch.vel_z       = o_vel_r[2];
  assign out_ch.out_rate_x  = o_rx_r;
  assign out_ch.out_rate_y  = o_ry_r;
  assign out_ch.out_rate_z  = o_rz_r;

endmodule

`default_nettype wire
